[hdl/image_container_stream_parser_defines.svh]
// Assertion macros used by the port-level checker of the image container stream parser.
// Depends on nothing; each macro expects a clock named i_clk, and ICSP_ASSERT a reset named i_rst_n.
`ifndef IMAGE_CONTAINER_STREAM_PARSER_DEFINES_SVH
`define IMAGE_CONTAINER_STREAM_PARSER_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define ICSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ICSP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[hdl/icsp_pkg.sv]
// Types and constants of the image container stream parser.
// Used by the parser top level, its shared multiplier and its checker.
package icsp_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [63:0] t_word;
    typedef logic [3:0]  t_phase;
    typedef logic [3:0]  t_event;
    typedef logic [3:0]  t_err;
    typedef logic [1:0]  t_cmd;

    localparam t_cmd CMD_DATA    = 2'd0;
    localparam t_cmd CMD_EOF     = 2'd1;
    localparam t_cmd CMD_RESTART = 2'd2;
    localparam t_cmd CMD_NONE    = 2'd3;

    localparam t_phase PH_MAGIC   = 4'd0;
    localparam t_phase PH_HSIZE   = 4'd1;
    localparam t_phase PH_CSIZE   = 4'd2;
    localparam t_phase PH_WIDTH   = 4'd3;
    localparam t_phase PH_HEIGHT  = 4'd4;
    localparam t_phase PH_CAPTION = 4'd5;
    localparam t_phase PH_TAGS    = 4'd6;
    localparam t_phase PH_PIXELS  = 4'd7;
    localparam t_phase PH_TRAILER = 4'd8;
    localparam t_phase PH_DONE    = 4'd9;

    localparam t_event EV_CONSUMED    = 4'd0;
    localparam t_event EV_HSIZE       = 4'd1;
    localparam t_event EV_CSIZE       = 4'd2;
    localparam t_event EV_WIDTH       = 4'd3;
    localparam t_event EV_HEIGHT      = 4'd4;
    localparam t_event EV_CAPTION_B   = 4'd5;
    localparam t_event EV_CAPTION_END = 4'd6;
    localparam t_event EV_TAG_B       = 4'd7;
    localparam t_event EV_TAG_END     = 4'd8;
    localparam t_event EV_PIXEL       = 4'd9;
    localparam t_event EV_ACCEPT      = 4'd10;
    localparam t_event EV_REJECT      = 4'd11;

    localparam t_err ERR_NONE      = 4'd0;
    localparam t_err ERR_MAGIC     = 4'd1;
    localparam t_err ERR_HDR_SMALL = 4'd2;
    localparam t_err ERR_SIZE      = 4'd3;
    localparam t_err ERR_TRUNC     = 4'd4;
    localparam t_err ERR_TAG_NL    = 4'd5;
    localparam t_err ERR_LAST_NUL  = 4'd6;
    localparam t_err ERR_EXTRA     = 4'd7;
    localparam t_err ERR_CAPTION   = 4'd8;

    localparam logic [31:0] MAGIC_WORD = 32'h4646_4943;
    localparam t_word       MIN_HEADER = 64'd38;
    localparam t_byte       NEWLINE    = 8'h0A;
    localparam t_byte       NUL        = 8'h00;

    localparam int OUT_DATA_W = 96;

endpackage

[hdl/image_container_stream_parser.sv]
// Top level of the image container stream parser: byte sequencer, field registers, output item.
// Depends on icsp_pkg and the shared multiplier icsp_mul.
//
// The parser takes one file byte per item and returns one result item per input item.
// Every item is taken as soon as the output register is free, except the last byte of the
// height field: it starts the shared shift-add multiplier for the size check, which holds
// the input off until the multiplier is idle again and the output is free. The input is ready whenever the
// sequencer is idle and the output register is empty or being emptied.
module image_container_stream_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  icsp_pkg::t_byte                 i_s_tdata,  // [7:0] data_byte
    input  icsp_pkg::t_cmd                  i_s_tuser,  // [1:0] command
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [63:0] field_value, [71:64] pixel_red, [79:72] pixel_green,
    // [87:80] pixel_blue, [91:88] error_code, [95:92] zero
    output logic [icsp_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output icsp_pkg::t_event                o_m_tuser   // [3:0] event_kind
);
    import icsp_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_MUL  = 1'b1;

    logic   r_state, n_state;
    t_phase r_phase, n_phase;
    t_word  r_seen, n_seen;
    t_word  r_acc, n_acc;
    t_word  r_hdr, n_hdr;
    t_word  r_payload, n_payload;
    t_word  r_width, n_width;
    t_word  r_height, n_height;
    t_word  r_pix_cnt, n_pix_cnt;
    logic [15:0] r_partial, n_partial;
    logic [1:0]  r_pix_idx, n_pix_idx;

    logic   r_ovalid, n_ovalid;
    t_event r_kind, n_kind;
    t_word  r_value, n_value;
    t_byte  r_red, n_red;
    t_byte  r_green, n_green;
    t_byte  r_blue, n_blue;
    t_err   r_err, n_err;

    logic   accept;
    logic   out_free;
    logic   mul_start;
    logic   mul_idle;
    t_word  mul_product;
    t_word  seen_inc;
    t_word  pix_inc;
    t_word  byte_ins;
    t_word  field_val;
    logic [2:0] field_idx;
    logic   seen_eq_hdr;
    logic   seen_lt_hdr;

    assign out_free   = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    assign seen_inc    = r_seen + 64'd1;
    assign pix_inc     = r_pix_cnt + 64'd1;
    assign seen_eq_hdr = (seen_inc == r_hdr);
    assign seen_lt_hdr = (seen_inc < r_hdr);
    assign field_idx   = r_seen[2:0] ^ 3'b100;
    assign field_val   = {i_s_tdata, r_acc[55:0]};

    always_comb begin
        byte_ins = r_acc;
        if (r_phase == PH_MAGIC) begin
            byte_ins = r_acc | ({56'd0, i_s_tdata} << {r_seen[1:0], 3'b000});
        end else begin
            byte_ins = r_acc | ({56'd0, i_s_tdata} << {field_idx, 3'b000});
        end
    end

    icsp_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_width   (r_width),
        .i_height  (field_val),
        .o_idle    (mul_idle),
        .o_product (mul_product)
    );

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_seen    = r_seen;
        n_acc     = r_acc;
        n_hdr     = r_hdr;
        n_payload = r_payload;
        n_width   = r_width;
        n_height  = r_height;
        n_pix_cnt = r_pix_cnt;
        n_partial = r_partial;
        n_pix_idx = r_pix_idx;
        n_ovalid  = r_ovalid && !i_m_tready;
        n_kind    = r_kind;
        n_value   = r_value;
        n_red     = r_red;
        n_green   = r_green;
        n_blue    = r_blue;
        n_err     = r_err;
        mul_start = 1'b0;

        if (r_state == S_MUL) begin
            if (mul_idle && out_free) begin
                n_state  = S_IDLE;
                n_ovalid = 1'b1;
                n_value  = '0;
                n_red    = '0;
                n_green  = '0;
                n_blue   = '0;
                if (r_payload != mul_product) begin
                    n_phase = PH_DONE;
                    n_kind  = EV_REJECT;
                    n_err   = ERR_SIZE;
                end else begin
                    n_phase = PH_CAPTION;
                    n_kind  = EV_HEIGHT;
                    n_value = r_height;
                    n_err   = ERR_NONE;
                end
            end
        end else if (accept) begin
            n_ovalid = 1'b1;
            n_kind   = EV_CONSUMED;
            n_value  = '0;
            n_red    = '0;
            n_green  = '0;
            n_blue   = '0;
            n_err    = ERR_NONE;
            if (i_s_tuser == CMD_RESTART) begin
                n_phase   = PH_MAGIC;
                n_seen    = '0;
                n_acc     = '0;
                n_hdr     = '0;
                n_payload = '0;
                n_width   = '0;
                n_height  = '0;
                n_pix_cnt = '0;
                n_partial = '0;
                n_pix_idx = '0;
            end else if (i_s_tuser == CMD_NONE || r_phase == PH_DONE) begin
                n_kind = EV_CONSUMED;
            end else if (i_s_tuser == CMD_EOF) begin
                n_phase = PH_DONE;
                if (r_phase == PH_TRAILER) begin
                    n_kind = EV_ACCEPT;
                end else begin
                    n_kind = EV_REJECT;
                    n_err  = ERR_TRUNC;
                end
            end else begin
                unique case (r_phase)
                    PH_MAGIC: begin
                        n_acc  = byte_ins;
                        n_seen = seen_inc;
                        if (r_seen[1:0] == 2'd3) begin
                            if (byte_ins[31:0] != MAGIC_WORD) begin
                                n_phase = PH_DONE;
                                n_kind  = EV_REJECT;
                                n_err   = ERR_MAGIC;
                            end else begin
                                n_acc   = '0;
                                n_phase = PH_HSIZE;
                            end
                        end
                    end
                    PH_HSIZE, PH_CSIZE, PH_WIDTH, PH_HEIGHT: begin
                        n_acc  = byte_ins;
                        n_seen = seen_inc;
                        if (field_idx == 3'd7) begin
                            n_acc = '0;
                            unique case (r_phase)
                                PH_HSIZE: begin
                                    n_hdr = field_val;
                                    if (field_val < MIN_HEADER) begin
                                        n_phase = PH_DONE;
                                        n_kind  = EV_REJECT;
                                        n_err   = ERR_HDR_SMALL;
                                    end else begin
                                        n_phase = PH_CSIZE;
                                        n_kind  = EV_HSIZE;
                                        n_value = field_val;
                                    end
                                end
                                PH_CSIZE: begin
                                    n_payload = field_val;
                                    n_phase   = PH_WIDTH;
                                    n_kind    = EV_CSIZE;
                                    n_value   = field_val;
                                end
                                PH_WIDTH: begin
                                    n_width = field_val;
                                    n_phase = PH_HEIGHT;
                                    n_kind  = EV_WIDTH;
                                    n_value = field_val;
                                end
                                default: begin
                                    n_height  = field_val;
                                    mul_start = 1'b1;
                                    n_state   = S_MUL;
                                    n_ovalid  = 1'b0;
                                end
                            endcase
                        end
                    end
                    PH_CAPTION: begin
                        n_seen = seen_inc;
                        if (i_s_tdata == NEWLINE && (seen_lt_hdr || seen_eq_hdr)) begin
                            if (seen_eq_hdr) begin
                                n_pix_idx = '0;
                                n_partial = '0;
                                n_pix_cnt = '0;
                                n_phase   = (r_payload == '0) ? PH_TRAILER : PH_PIXELS;
                            end else begin
                                n_phase = PH_TAGS;
                            end
                            n_kind  = EV_CAPTION_END;
                            n_value = {56'd0, NEWLINE};
                        end else if (!seen_lt_hdr) begin
                            n_phase = PH_DONE;
                            n_kind  = EV_REJECT;
                            n_err   = ERR_CAPTION;
                        end else begin
                            n_kind  = EV_CAPTION_B;
                            n_value = {56'd0, i_s_tdata};
                        end
                    end
                    PH_TAGS: begin
                        n_seen = seen_inc;
                        if (i_s_tdata == NEWLINE) begin
                            n_phase = PH_DONE;
                            n_kind  = EV_REJECT;
                            n_err   = ERR_TAG_NL;
                        end else if (seen_eq_hdr && i_s_tdata != NUL) begin
                            n_phase = PH_DONE;
                            n_kind  = EV_REJECT;
                            n_err   = ERR_LAST_NUL;
                        end else begin
                            if (seen_eq_hdr) begin
                                n_pix_idx = '0;
                                n_partial = '0;
                                n_pix_cnt = '0;
                                n_phase   = (r_payload == '0) ? PH_TRAILER : PH_PIXELS;
                            end
                            if (i_s_tdata == NUL) begin
                                n_kind = EV_TAG_END;
                            end else begin
                                n_kind  = EV_TAG_B;
                                n_value = {56'd0, i_s_tdata};
                            end
                        end
                    end
                    PH_PIXELS: begin
                        n_seen    = seen_inc;
                        n_pix_cnt = pix_inc;
                        if (r_pix_idx == 2'd0) begin
                            n_partial = {8'd0, i_s_tdata};
                            n_pix_idx = 2'd1;
                        end else if (r_pix_idx == 2'd1) begin
                            n_partial = {i_s_tdata, r_partial[7:0]};
                            n_pix_idx = 2'd2;
                        end else begin
                            n_pix_idx = 2'd0;
                            n_partial = '0;
                            n_kind    = EV_PIXEL;
                            n_red     = r_partial[7:0];
                            n_green   = r_partial[15:8];
                            n_blue    = i_s_tdata;
                            if (pix_inc >= r_payload) begin
                                n_phase = PH_TRAILER;
                            end
                        end
                    end
                    PH_TRAILER: begin
                        n_phase = PH_DONE;
                        n_kind  = EV_REJECT;
                        n_err   = ERR_EXTRA;
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_MAGIC;
            r_seen    <= '0;
            r_acc     <= '0;
            r_hdr     <= '0;
            r_payload <= '0;
            r_width   <= '0;
            r_height  <= '0;
            r_pix_cnt <= '0;
            r_partial <= '0;
            r_pix_idx <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_seen    <= n_seen;
            r_acc     <= n_acc;
            r_hdr     <= n_hdr;
            r_payload <= n_payload;
            r_width   <= n_width;
            r_height  <= n_height;
            r_pix_cnt <= n_pix_cnt;
            r_partial <= n_partial;
            r_pix_idx <= n_pix_idx;
            r_ovalid  <= n_ovalid;
        end
        r_kind  <= n_kind;
        r_value <= n_value;
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
        r_err   <= n_err;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_kind;
    assign o_m_tdata  = {4'd0, r_err, r_blue, r_green, r_red, r_value};

endmodule

[hdl/icsp_mul.sv]
// Shared shift-add unit of the parser: forms width * height * 3 modulo 2^64.
// One adder serves both the multiply steps and the final tripling step.
module icsp_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  icsp_pkg::t_word     i_width,
    input  icsp_pkg::t_word     i_height,
    output logic                o_idle,
    output icsp_pkg::t_word     o_product
);
    import icsp_pkg::*;

    localparam logic [1:0] M_IDLE   = 2'd0;
    localparam logic [1:0] M_MUL    = 2'd1;
    localparam logic [1:0] M_TRIPLE = 2'd2;

    logic [1:0] r_state, n_state;
    t_word      r_a, n_a;
    t_word      r_b, n_b;
    t_word      r_p, n_p;
    t_word      addend;
    t_word      sum;

    assign addend = (r_state == M_TRIPLE) ? {r_p[62:0], 1'b0} : r_a;
    assign sum    = r_p + addend;

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_p     = r_p;
        unique case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_a     = i_width;
                    n_b     = i_height;
                    n_p     = '0;
                    n_state = M_MUL;
                end
            end
            M_MUL: begin
                if (r_b == '0) begin
                    n_state = M_TRIPLE;
                end else begin
                    if (r_b[0]) begin
                        n_p = sum;
                    end
                    n_a = {r_a[62:0], 1'b0};
                    n_b = {1'b0, r_b[63:1]};
                end
            end
            M_TRIPLE: begin
                n_p     = sum;
                n_state = M_IDLE;
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_a <= n_a;
        r_b <= n_b;
        r_p <= n_p;
    end

    assign o_idle    = (r_state == M_IDLE);
    assign o_product = r_p;

endmodule

[hdl/icsp_checker.sv]
// Port-level checker of the image container stream parser, bound to the top level.
// Depends on icsp_pkg and image_container_stream_parser_defines.svh.
`include "image_container_stream_parser_defines.svh"

module icsp_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_s_tready,
    input  logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [icsp_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input  icsp_pkg::t_event                o_m_tuser
);
    import icsp_pkg::*;

    t_err        out_err;
    logic [23:0] out_rgb;
    logic        is_reject;

    assign out_err   = o_m_tdata[91:88];
    assign out_rgb   = o_m_tdata[87:64];
    assign is_reject = (o_m_tuser == EV_REJECT);

    `ICSP_ASSERT(a_hold_valid, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "output item dropped")
    `ICSP_ASSERT_RST(a_rst_clear, !i_rst_n |=> !o_m_tvalid, "output valid after reset")
    `ICSP_ASSERT(a_ready_slot, o_s_tready |-> (!o_m_tvalid || i_m_tready), "ready over full output")
    `ICSP_ASSERT(a_err_reject, o_m_tvalid |-> (is_reject == (out_err != ERR_NONE)), "bad error code")
    `ICSP_ASSERT(a_rgb_pixel, o_m_tvalid && (o_m_tuser != EV_PIXEL) |-> (out_rgb == 24'd0), "stray rgb")

endmodule

bind image_container_stream_parser icsp_checker u_icsp_checker (.*);

[test/image_container_stream_parser_checker.sv]
// Checker for the image container stream parser: watches both stream channels,
// predicts one result per input item and compares every field but the zero bits, in order.
// Depends on icsp_pkg for the command, event and error codes.
module image_container_stream_parser_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  icsp_pkg::t_byte                 i_s_tdata,  // [7:0] data_byte
    input  icsp_pkg::t_cmd                  i_s_tuser,  // [1:0] command
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // [63:0] field_value, [71:64] pixel_red, [79:72] pixel_green,
    // [87:80] pixel_blue, [91:88] error_code, [95:92] zero
    input  logic [icsp_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  icsp_pkg::t_event                i_m_tuser,  // [3:0] event_kind
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_items_in,
    output int                              o_results,
    output int                              o_accepts,
    output int                              o_rejects,
    output logic [15:0]                     o_err_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import icsp_pkg::*;

    typedef struct packed {
        t_event kind;
        t_word  value;
        t_byte  red;
        t_byte  green;
        t_byte  blue;
        t_err   err;
    } t_parse_result;

    t_parse_result expected_events[$];

    t_phase      cur_phase;
    t_word       byte_count;
    t_word       field_acc;
    t_word       hdr_len;
    t_word       payload_len;
    t_word       img_width;
    t_word       img_height;
    logic [15:0] pend_pixel;
    logic [1:0]  pix_slot;

    function automatic void clear_parser();
        cur_phase   = PH_MAGIC;
        byte_count  = '0;
        field_acc   = '0;
        hdr_len     = '0;
        payload_len = '0;
        img_width   = '0;
        img_height  = '0;
        pend_pixel  = '0;
        pix_slot    = '0;
    endfunction

    function automatic t_parse_result make_result(t_event kind, t_word value, t_err err);
        t_parse_result res;
        res       = '0;
        res.kind  = kind;
        res.value = value;
        res.err   = err;
        return res;
    endfunction

    function automatic t_parse_result reject_file(t_err err);
        cur_phase = PH_DONE;
        return make_result(EV_REJECT, '0, err);
    endfunction

    function automatic void start_pixels();
        pix_slot   = '0;
        pend_pixel = '0;
        cur_phase  = (payload_len == '0) ? PH_TRAILER : PH_PIXELS;
    endfunction

    function automatic t_parse_result predict_event(t_cmd cmd, t_byte b);
        t_parse_result res;
        t_word         word;
        t_word         offset;
        res = make_result(EV_CONSUMED, '0, ERR_NONE);
        if (cmd == CMD_RESTART) begin
            clear_parser();
            return res;
        end
        if (cmd == CMD_NONE || cur_phase == PH_DONE)
            return res;
        if (cmd == CMD_EOF) begin
            if (cur_phase != PH_TRAILER)
                return reject_file(ERR_TRUNC);
            cur_phase = PH_DONE;
            return make_result(EV_ACCEPT, '0, ERR_NONE);
        end
        offset     = byte_count;
        byte_count = byte_count + 64'd1;
        case (cur_phase)
            PH_MAGIC: begin
                field_acc |= t_word'(b) << (8 * offset[1:0]);
                if (byte_count < 64'd4)
                    return res;
                if (field_acc != t_word'(MAGIC_WORD))
                    return reject_file(ERR_MAGIC);
                field_acc = '0;
                cur_phase = PH_HSIZE;
                return res;
            end
            PH_HSIZE, PH_CSIZE, PH_WIDTH, PH_HEIGHT: begin
                offset = offset - 64'd4;
                field_acc |= t_word'(b) << (8 * offset[2:0]);
                if (offset[2:0] != 3'd7)
                    return res;
                word      = field_acc;
                field_acc = '0;
                case (cur_phase)
                    PH_HSIZE: begin
                        hdr_len = word;
                        if (word < MIN_HEADER)
                            return reject_file(ERR_HDR_SMALL);
                        cur_phase = PH_CSIZE;
                        return make_result(EV_HSIZE, word, ERR_NONE);
                    end
                    PH_CSIZE: begin
                        payload_len = word;
                        cur_phase   = PH_WIDTH;
                        return make_result(EV_CSIZE, word, ERR_NONE);
                    end
                    PH_WIDTH: begin
                        img_width = word;
                        cur_phase = PH_HEIGHT;
                        return make_result(EV_WIDTH, word, ERR_NONE);
                    end
                    default: begin
                        img_height = word;
                        if (payload_len != img_width * img_height * 64'd3)
                            return reject_file(ERR_SIZE);
                        cur_phase = PH_CAPTION;
                        return make_result(EV_HEIGHT, word, ERR_NONE);
                    end
                endcase
            end
            PH_CAPTION: begin
                if (b == NEWLINE && byte_count <= hdr_len) begin
                    if (byte_count == hdr_len)
                        start_pixels();
                    else
                        cur_phase = PH_TAGS;
                    return make_result(EV_CAPTION_END, t_word'(NEWLINE), ERR_NONE);
                end
                if (byte_count >= hdr_len)
                    return reject_file(ERR_CAPTION);
                return make_result(EV_CAPTION_B, t_word'(b), ERR_NONE);
            end
            PH_TAGS: begin
                if (b == NEWLINE)
                    return reject_file(ERR_TAG_NL);
                if (byte_count == hdr_len) begin
                    if (b != NUL)
                        return reject_file(ERR_LAST_NUL);
                    start_pixels();
                end
                if (b == NUL)
                    return make_result(EV_TAG_END, '0, ERR_NONE);
                return make_result(EV_TAG_B, t_word'(b), ERR_NONE);
            end
            PH_PIXELS: begin
                if (pix_slot == 2'd0) begin
                    pend_pixel = {8'h00, b};
                    pix_slot   = 2'd1;
                    return res;
                end
                if (pix_slot == 2'd1) begin
                    pend_pixel[15:8] = b;
                    pix_slot         = 2'd2;
                    return res;
                end
                res       = make_result(EV_PIXEL, '0, ERR_NONE);
                res.red   = pend_pixel[7:0];
                res.green = pend_pixel[15:8];
                res.blue  = b;
                pix_slot   = 2'd0;
                pend_pixel = '0;
                if (byte_count - hdr_len >= payload_len)
                    cur_phase = PH_TRAILER;
                return res;
            end
            PH_TRAILER:
                return reject_file(ERR_EXTRA);
            default: begin
                cur_phase = PH_DONE;
                return res;
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string field, t_word got, t_word want);
        o_fail_count++;
        $display("mismatch at %0t ns, result %0d: %s is 0x%0h, predicted 0x%0h",
                 $time, o_results, field, got, want);
    endtask

    always @(posedge i_clk) begin
        t_parse_result want;
        t_parse_result got;
        if (!i_rst_n) begin
            clear_parser();
            expected_events.delete();
            o_pending  = 0;
            o_err_seen = '0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                expected_events.insert(expected_events.size(),
                                       predict_event(i_s_tuser, i_s_tdata));
                o_items_in++;
            end
            if (i_m_tvalid && i_m_tready) begin
                got.kind  = i_m_tuser;
                got.value = i_m_tdata[63:0];
                got.red   = i_m_tdata[71:64];
                got.green = i_m_tdata[79:72];
                got.blue  = i_m_tdata[87:80];
                got.err   = i_m_tdata[91:88];
                if (expected_events.size() == 0) begin
                    report_mismatch("result with no item waiting, event_kind",
                                    t_word'(got.kind), '0);
                end else begin
                    want = expected_events.pop_front();
                    if (got.kind != want.kind)
                        report_mismatch("event_kind", t_word'(got.kind), t_word'(want.kind));
                    if (got.value != want.value)
                        report_mismatch("field_value", got.value, want.value);
                    if (got.red != want.red)
                        report_mismatch("pixel_red", t_word'(got.red), t_word'(want.red));
                    if (got.green != want.green)
                        report_mismatch("pixel_green", t_word'(got.green), t_word'(want.green));
                    if (got.blue != want.blue)
                        report_mismatch("pixel_blue", t_word'(got.blue), t_word'(want.blue));
                    if (got.err != want.err)
                        report_mismatch("error_code", t_word'(got.err), t_word'(want.err));
                    if (want.kind == EV_ACCEPT)
                        o_accepts++;
                    if (want.kind == EV_REJECT) begin
                        o_rejects++;
                        o_err_seen[want.err] = 1'b1;
                    end
                end
                o_results++;
            end
            o_pending = expected_events.size();
        end
    end

endmodule

[test/image_container_stream_parser_tb.sv]
// Testbench top for the image container stream parser: clock, reset, file stimulus
// with idling and back-pressure, watchdog and verdict.
// Depends on icsp_pkg, the parser RTL and image_container_stream_parser_checker.
module image_container_stream_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import icsp_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int PHASE_ITEMS   = 190;
    localparam int HOLD_CYCLES   = 300;
    localparam int STUCK_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 20;
    localparam int N_MIXES       = 4;

    typedef struct packed {
        t_cmd  cmd;
        t_byte data;
    } t_stream_item;

    typedef enum int {
        FLAW_NONE,
        FLAW_MAGIC,
        FLAW_HDR_SMALL,
        FLAW_SIZE,
        FLAW_TRUNCATE,
        FLAW_TAG_NL,
        FLAW_LAST_NOT_NUL,
        FLAW_EXTRA,
        FLAW_CAPTION_RUN,
        FLAW_HUGE,
        FLAW_NOISE,
        FLAW_EARLY_RESTART
    } t_file_flaw;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    t_byte                 s_tdata  = '0;
    t_cmd                  s_tuser  = CMD_DATA;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    t_event                m_tuser;

    int          fail_count;
    int          pending;
    int          items_in;
    int          results;
    int          accepts;
    int          rejects;
    logic [15:0] err_seen;

    t_stream_item file_items[$];
    int           idle_pct      = 0;
    int           stall_pct     = 0;
    int           hold_requests = 0;
    int           hold_served   = 0;
    int           hold_left     = 0;
    int           items_sent    = 0;
    int           files_sent    = 0;
    int           stuck_cycles  = 0;
    bit           sprinkle_none = 1'b0;

    image_container_stream_parser uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    image_container_stream_parser_checker parse_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_items_in   (items_in),
        .o_results    (results),
        .o_accepts    (accepts),
        .o_rejects    (rejects),
        .o_err_seen   (err_seen)
    );

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    initial begin
        forever begin
            @(posedge clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("no item moved for %0d cycles", STUCK_LIMIT);
            $display("image_container_stream_parser regression: fail");
            $finish;
        end
    end

    function automatic void push_item(t_cmd cmd, t_byte data);
        t_stream_item item;
        item.cmd  = cmd;
        item.data = data;
        file_items.insert(file_items.size(), item);
    endfunction

    function automatic void push_data(t_byte b);
        if (sprinkle_none && $urandom_range(99) < 3)
            push_item(CMD_NONE, t_byte'($urandom_range(255)));
        push_item(CMD_DATA, b);
    endfunction

    function automatic void push_word(t_word w);
        int i;
        for (i = 0; i < 8; i++)
            push_data(w[8*i +: 8]);
    endfunction

    function automatic t_byte text_byte();
        t_byte b;
        do
            b = t_byte'($urandom_range(255));
        while (b == NEWLINE || b == NUL);
        return b;
    endfunction

    task automatic send_item(t_cmd cmd, t_byte data);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_file();
        int i;
        for (i = 0; i < file_items.size(); i++)
            send_item(file_items[i].cmd, file_items[i].data);
        files_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic run_directed();
        int i;
        file_items.delete();
        push_item(CMD_NONE, 8'hFF);
        push_item(CMD_EOF, 8'h00);
        push_item(CMD_DATA, 8'hA5);
        push_item(CMD_EOF, 8'h00);
        push_item(CMD_RESTART, 8'h5A);
        for (i = 0; i < 3; i++)
            push_data(MAGIC_WORD[8*i +: 8]);
        push_item(CMD_EOF, 8'h00);
        push_item(CMD_RESTART, 8'h00);
        repeat (4) push_data(8'hFF);
        push_item(CMD_RESTART, 8'h00);
        for (i = 0; i < 4; i++)
            push_data(MAGIC_WORD[8*i +: 8]);
        push_word(MIN_HEADER - 64'd1);
        push_item(CMD_RESTART, 8'h00);
        for (i = 0; i < 4; i++)
            push_data(MAGIC_WORD[8*i +: 8]);
        push_word(MIN_HEADER);
        push_word('0);
        push_word('0);
        push_word('0);
        push_data(NEWLINE);
        push_data(NUL);
        push_item(CMD_EOF, 8'h00);
        push_item(CMD_DATA, 8'hFF);
        push_item(CMD_RESTART, 8'hFF);
        for (i = 0; i < 4; i++)
            push_data(MAGIC_WORD[8*i +: 8]);
        push_word(MIN_HEADER);
        push_word(64'd3);
        push_word('1);
        push_word('1);
        push_data(8'h41);
        push_data(NEWLINE);
        push_data(8'hFF);
        push_data(8'h00);
        push_data(8'h80);
        push_item(CMD_EOF, 8'hFF);
        send_file();
    endtask

    task automatic build_random_file();
        t_file_flaw flaw;
        t_word      hs;
        t_word      wd;
        t_word      ht;
        t_word      content;
        int         region;
        int         cap_len;
        int         rest;
        int         bad_pos;
        int         n_pix;
        int         keep;
        int         i;
        file_items.delete();
        push_item(CMD_RESTART, t_byte'($urandom_range(255)));
        flaw = ($urandom_range(99) < 50) ? FLAW_NONE
             : t_file_flaw'($urandom_range(1, FLAW_EARLY_RESTART));
        bad_pos = (flaw == FLAW_MAGIC) ? int'($urandom_range(0, 3)) : -1;
        if (flaw == FLAW_NOISE) begin
            if ($urandom_range(1))
                for (i = 0; i < 4; i++)
                    push_data(MAGIC_WORD[8*i +: 8]);
            repeat ($urandom_range(4, 24))
                push_item(($urandom_range(7) == 0) ? t_cmd'($urandom_range(3)) : CMD_DATA,
                          t_byte'($urandom_range(255)));
            return;
        end
        for (i = 0; i < 4; i++)
            push_data((i == bad_pos) ? t_byte'($urandom_range(255)) : MAGIC_WORD[8*i +: 8]);
        hs = ($urandom_range(2) == 0) ? MIN_HEADER : MIN_HEADER + t_word'($urandom_range(1, 12));
        wd = t_word'($urandom_range(0, 3));
        ht = t_word'($urandom_range(0, 2));
        if (flaw == FLAW_HDR_SMALL)
            hs = t_word'($urandom_range(0, 37));
        if (flaw == FLAW_HUGE) begin
            wd = {$urandom, $urandom};
            ht = {$urandom, $urandom};
            if ($urandom_range(1))
                hs = {$urandom, $urandom};
        end
        content = wd * ht * 64'd3;
        if (flaw == FLAW_SIZE)
            content ^= t_word'(1) << $urandom_range(63);
        push_word(hs);
        push_word(content);
        push_word(wd);
        push_word(ht);
        if (hs < MIN_HEADER || hs > 64'd100) begin
            repeat ($urandom_range(0, 40))
                push_data(t_byte'($urandom_range(255)));
        end else if (flaw == FLAW_CAPTION_RUN) begin
            region = int'(hs) - 36;
            repeat (region) push_data(text_byte());
        end else begin
            region = int'(hs) - 36;
            if (flaw == FLAW_TAG_NL || flaw == FLAW_LAST_NOT_NUL)
                cap_len = int'($urandom_range(0, region - 2));
            else
                cap_len = int'($urandom_range(0, region - 1));
            repeat (cap_len) push_data(text_byte());
            push_data(NEWLINE);
            rest    = region - cap_len - 1;
            bad_pos = (flaw == FLAW_TAG_NL) ? int'($urandom_range(0, rest - 1)) : -1;
            for (i = 0; i < rest; i++) begin
                if (i == bad_pos)
                    push_data(NEWLINE);
                else if (i == rest - 1)
                    push_data((flaw == FLAW_LAST_NOT_NUL) ? text_byte() : NUL);
                else
                    push_data(($urandom_range(3) == 0) ? NUL : text_byte());
            end
        end
        n_pix = (content > 64'd60) ? int'($urandom_range(0, 12)) : int'(content);
        repeat (n_pix) push_data(t_byte'($urandom_range(255)));
        if (flaw == FLAW_EXTRA)
            repeat ($urandom_range(1, 3)) push_data(t_byte'($urandom_range(255)));
        if (flaw == FLAW_TRUNCATE || flaw == FLAW_EARLY_RESTART) begin
            keep = int'($urandom_range(1, file_items.size() - 1));
            while (file_items.size() > keep)
                void'(file_items.pop_back());
        end
        if (flaw != FLAW_EARLY_RESTART)
            push_item(CMD_EOF, t_byte'($urandom_range(255)));
        if ($urandom_range(3) == 0)
            push_item(t_cmd'($urandom_range(1)), t_byte'($urandom_range(255)));
    endtask

    initial begin
        int mix;
        int mix_end;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        drain_results();
        sprinkle_none = 1'b1;
        for (mix = 0; mix < N_MIXES; mix++) begin
            case (mix)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    hold_requests++;
                end
                1: begin
                    idle_pct  = 52;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 52;
                end
                default: begin
                    idle_pct  = 24;
                    stall_pct = 24;
                end
            endcase
            mix_end = items_sent + PHASE_ITEMS;
            while (items_sent < mix_end) begin
                build_random_file();
                send_file();
            end
            drain_results();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("ran %0d input items in %0d files under four idling mixes and a long output hold",
                 items_in, files_sent);
        $display("checked %0d results: %0d files accepted, %0d rejected, reject codes 8..1 seen %b",
                 results, accepts, rejects, err_seen[8:1]);
        if (pending != 0)
            $display("%0d predicted results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("image_container_stream_parser regression: pass");
        end else begin
            $display("image_container_stream_parser regression: fail");
        end
        $finish;
    end

endmodule

[image_container_stream_parser.f]
+incdir+hdl
hdl/icsp_pkg.sv
hdl/icsp_mul.sv
hdl/image_container_stream_parser.sv
hdl/icsp_checker.sv
test/image_container_stream_parser_checker.sv
test/image_container_stream_parser_tb.sv
